[hw/rtl/sllp_pkg.sv]
// shared types and constants of the song-length line parser
package sllp_pkg;

  localparam int HASH_BYTES  = 16;
  localparam int HASH_DIGITS = 2 * HASH_BYTES;
  localparam int HCNT_W      = $clog2(HASH_DIGITS + 2);

  localparam int RES_DEPTH   = 8;
  localparam int RES_PTR_W   = $clog2(RES_DEPTH);
  localparam int RES_CNT_W   = $clog2(RES_DEPTH + 1);

  localparam logic [23:0] MAX24 = 24'hFFFFFF;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_BRACK = 8'h5B;

  // result kinds
  localparam logic [1:0] KIND_HASH   = 2'd0;
  localparam logic [1:0] KIND_LENGTH = 2'd1;
  localparam logic [1:0] KIND_STATUS = 2'd2;

  // line status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_IGNORED   = 3'd1;
  localparam logic [2:0] ST_BAD_HASH  = 3'd2;
  localparam logic [2:0] ST_BAD_ENTRY = 3'd3;
  localparam logic [2:0] ST_BAD_LINE  = 3'd4;

  typedef enum logic [2:0] {
    PH_START,
    PH_IGNORE,
    PH_BADLINE,
    PH_HASH,
    PH_BADHASH,
    PH_NOEQ,
    PH_ENTRIES
  } line_phase_t;

  typedef enum logic [1:0] {
    TP_GAP,
    TP_MIN,
    TP_SEC,
    TP_ATTR
  } time_phase_t;

  typedef struct packed {
    line_phase_t         phase;
    time_phase_t         tphase;
    logic [HCNT_W-1:0]   hex_cnt;
    logic [3:0]          high;
    logic [23:0]         minutes;
    logic [23:0]         seconds;
    logic [7:0]          count;
    logic                stopped;
  } line_state_t;

  localparam line_state_t LINE_RESET = '{
    phase:   PH_START,
    tphase:  TP_GAP,
    hex_cnt: '0,
    high:    '0,
    minutes: '0,
    seconds: '0,
    count:   '0,
    stopped: 1'b0
  };

  typedef struct packed {
    logic [1:0]  kind;
    logic [23:0] value;
    logic [7:0]  position;
    logic [2:0]  status;
    logic        last;
  } result_t;

endpackage

[hw/rtl/sllp_step.sv]
// per-character parse step: next line state and up to two results
module sllp_step (
  input  sllp_pkg::line_state_t st,
  input  logic [7:0]            char_code,
  input  logic                  end_of_line,
  output sllp_pkg::line_state_t st_next,
  output logic [1:0]            res_valid,
  output sllp_pkg::result_t     res [2]
);
  import sllp_pkg::*;

  function automatic logic is_blank(input logic [7:0] c);
    return (c == 8'd32) || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= 8'h39);
  endfunction

  // 16 means not a hex digit
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [7:0] d;
    d = 8'd16;
    if (is_digit(c)) begin
      d = c - CH_ZERO;
    end else if (c >= 8'h61 && c <= 8'h66) begin
      d = c - 8'h57;
    end else if (c >= 8'h41 && c <= 8'h46) begin
      d = c - 8'h37;
    end
    return d[4:0];
  endfunction

  function automatic logic [23:0] acc_digit(input logic [23:0] a, input logic [7:0] c);
    logic [27:0] v;
    logic [7:0]  d;
    d = c - CH_ZERO;
    v = ({4'd0, a} << 3) + ({4'd0, a} << 1) + {20'd0, d};
    return (v > {4'd0, MAX24}) ? MAX24 : v[23:0];
  endfunction

  line_state_t n;
  logic [4:0]  hv;
  logic        emit_mid;
  logic        emit_len;
  logic [30:0] total;
  logic [23:0] total_sat;
  logic [2:0]  line_status;

  always_comb begin
    n        = st;
    hv       = hex_value(char_code);
    emit_mid = 1'b0;
    res_valid = 2'b00;
    res[0]   = '0;
    res[1]   = '0;

    case (st.phase)
      PH_START: begin
        if (is_blank(char_code)) begin
        end else if (!hv[4]) begin
          n.phase   = PH_HASH;
          n.hex_cnt = HCNT_W'(1);
          n.high    = hv[3:0];
        end else if (char_code == CH_SEMI || char_code == CH_BRACK) begin
          n.phase = PH_IGNORE;
        end else begin
          n.phase = PH_BADLINE;
        end
      end
      PH_HASH: begin
        if (!hv[4]) begin
          if (st.hex_cnt < HCNT_W'(HASH_DIGITS)) begin
            if (st.hex_cnt[0]) begin
              res_valid[0] = 1'b1;
              res[0].kind     = KIND_HASH;
              res[0].value    = {16'd0, st.high, hv[3:0]};
              res[0].position = 8'(st.hex_cnt >> 1);
            end else begin
              n.high = hv[3:0];
            end
            n.hex_cnt = st.hex_cnt + HCNT_W'(1);
          end else begin
            n.hex_cnt = HCNT_W'(HASH_DIGITS + 1);
          end
        end else if (st.hex_cnt != HCNT_W'(HASH_DIGITS)) begin
          n.phase = PH_BADHASH;
        end else if (char_code == CH_EQ) begin
          n.phase  = PH_ENTRIES;
          n.tphase = TP_GAP;
        end else begin
          n.phase = PH_NOEQ;
        end
      end
      PH_ENTRIES: begin
        if (!st.stopped) begin
          case (st.tphase)
            TP_GAP: begin
              if (is_blank(char_code)) begin
              end else if (is_digit(char_code)) begin
                n.tphase  = TP_MIN;
                n.minutes = {16'd0, char_code - CH_ZERO};
              end else begin
                n.stopped = 1'b1;
              end
            end
            TP_MIN: begin
              if (is_digit(char_code)) begin
                n.minutes = acc_digit(st.minutes, char_code);
              end else if (char_code == CH_COLON) begin
                n.tphase  = TP_SEC;
                n.seconds = '0;
              end else begin
                n.stopped = 1'b1;
              end
            end
            TP_SEC: begin
              if (is_digit(char_code)) begin
                n.seconds = acc_digit(st.seconds, char_code);
              end else begin
                emit_mid = 1'b1;
                n.tphase = is_blank(char_code) ? TP_GAP : TP_ATTR;
              end
            end
            default: begin
              if (is_blank(char_code)) n.tphase = TP_GAP;
            end
          endcase
        end
      end
      default: begin
      end
    endcase

    // an entry still in its seconds field at end of line is closed here
    emit_len = emit_mid || (end_of_line && n.phase == PH_ENTRIES && !n.stopped &&
                            n.tphase == TP_SEC);
    total = ({7'd0, n.minutes} << 6) - ({7'd0, n.minutes} << 2) + {7'd0, n.seconds};
    total_sat = (total > {7'd0, MAX24}) ? MAX24 : total[23:0];
    if (emit_len) begin
      res_valid[0]    = 1'b1;
      res[0].kind     = KIND_LENGTH;
      res[0].value    = total_sat;
      res[0].position = n.count;
      if (n.count != 8'hFF) n.count = n.count + 8'd1;
    end

    case (n.phase)
      PH_START, PH_IGNORE: line_status = ST_IGNORED;
      PH_BADLINE:          line_status = ST_BAD_LINE;
      PH_HASH:             line_status = (n.hex_cnt == HCNT_W'(HASH_DIGITS)) ?
                                         ST_BAD_ENTRY : ST_BAD_HASH;
      PH_BADHASH:          line_status = ST_BAD_HASH;
      PH_NOEQ:             line_status = ST_BAD_ENTRY;
      default:             line_status = (n.count != 8'd0) ? ST_OK : ST_BAD_ENTRY;
    endcase

    if (end_of_line) begin
      res_valid[1]    = 1'b1;
      res[1].kind     = KIND_STATUS;
      res[1].value    = {16'd0, n.count};
      res[1].position = 8'd0;
      res[1].status   = line_status;
      res[1].last     = 1'b1;
      n = LINE_RESET;
    end

    st_next = n;
  end

endmodule

[hw/rtl/sllp_res_fifo.sv]
// result queue: takes up to two results a cycle, gives one beat a cycle while pop is high
module sllp_res_fifo (
  input  logic                           clk,
  input  logic                           rst,
  input  logic [1:0]                     push,
  input  sllp_pkg::result_t              din [2],
  input  logic                           pop,
  output logic                           valid,
  output sllp_pkg::result_t              head,
  output logic [sllp_pkg::RES_CNT_W-1:0] count
);
  import sllp_pkg::*;

  result_t              mem [RES_DEPTH];
  logic [RES_PTR_W-1:0] wr_ptr;
  logic [RES_PTR_W-1:0] rd_ptr;
  logic [RES_PTR_W-1:0] wr_ptr_next;
  logic [RES_CNT_W-1:0] count_next;
  logic                 do_pop;

  assign valid  = (count != '0);
  assign head   = mem[rd_ptr];
  assign do_pop = pop && valid;

  always_comb begin
    wr_ptr_next = wr_ptr + RES_PTR_W'(push[0]) + RES_PTR_W'(push[1]);
    count_next  = count + RES_CNT_W'(push[0]) + RES_CNT_W'(push[1]) -
                  RES_CNT_W'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr_next;
      count  <= count_next;
      if (do_pop) rd_ptr <= rd_ptr + RES_PTR_W'(1);
    end
  end

  // second result lands behind the first when both are present
  always_ff @(posedge clk) begin
    if (push[0]) mem[wr_ptr] <= din[0];
    if (push[1]) mem[wr_ptr + RES_PTR_W'(push[0])] <= din[1];
  end

endmodule

[hw/rtl/song_length_line_parser.sv]
// top level of the song-length line parser
//
// One character of a database line comes in per beat on the s_ side,
// s_tlast marking the final character of the line. Results leave on the
// m_ side, one per beat: hash bytes, play lengths in seconds, and on the
// last character of every line a status beat with m_tlast high.
// A character is held in the input register, then the parse step
// updates the line state and writes zero, one or two results into an
// eight-entry result queue that drives m_tvalid; a character passes the
// input register and its results the queue before they can leave.
// Throughput is one character per cycle; s_tready drops only when the
// result queue could not absorb two more results from each character
// still in flight, so a receiver that holds m_tready low fills the queue
// and then stalls the sender without losing or repeating any beat.
// Reset (rst, synchronous) empties the queue and the input register and
// returns the line state to start of line.
module song_length_line_parser (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // char_code
  input  logic        s_tlast,   // end_of_line
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // value[23:0], position[31:24], status[34:32], zero pad
  output logic [1:0]  m_tuser,   // kind
  output logic        m_tlast    // last
);
  import sllp_pkg::*;

  logic                 in_valid;
  logic [7:0]           in_char;
  logic                 in_eol;
  line_state_t          line_st;
  line_state_t          line_st_next;
  logic [1:0]           res_valid;
  result_t              res [2];
  result_t              head;
  logic [RES_CNT_W-1:0] q_count;
  logic [RES_CNT_W:0]   q_need;

  assign q_need   = {1'b0, q_count} + (in_valid ? (RES_CNT_W + 1)'(2) : '0);
  assign s_tready = (q_need <= (RES_CNT_W + 1)'(RES_DEPTH - 2));

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      line_st  <= LINE_RESET;
    end else begin
      in_valid <= s_tvalid && s_tready;
      if (in_valid) line_st <= line_st_next;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_char <= s_tdata;
      in_eol  <= s_tlast;
    end
  end

  sllp_step u_step (
    .st          (line_st),
    .char_code   (in_char),
    .end_of_line (in_eol),
    .st_next     (line_st_next),
    .res_valid   (res_valid),
    .res         (res)
  );

  sllp_res_fifo u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (in_valid ? res_valid : 2'b00),
    .din   (res),
    .pop   (m_tready),
    .valid (m_tvalid),
    .head  (head),
    .count (q_count)
  );

  assign m_tdata = {5'd0, head.status, head.position, head.value};
  assign m_tuser = head.kind;
  assign m_tlast = head.last;

endmodule

[hw/rtl/sllp_checker.sv]
// port-level checks of the song-length line parser, bound to the top level
module sllp_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [39:0] m_tdata,
  input logic [1:0]  m_tuser,
  input logic        m_tlast
);
  import sllp_pkg::*;

  // stalled output beat holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser) &&
                              $stable(m_tlast))
    else $error("output beat changed while stalled");

  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid right after reset");

  a_last_is_status: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tlast == (m_tuser == KIND_STATUS)))
    else $error("tlast does not match status beat");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[34:32] <= ST_BAD_LINE) && (m_tuser <= KIND_STATUS) &&
                 (m_tdata[39:35] == 5'd0))
    else $error("bad status or kind code");

  a_data_beat_clean: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == KIND_HASH || m_tuser == KIND_LENGTH) |->
      (m_tdata[34:32] == ST_OK) && (m_tuser != KIND_HASH || m_tdata[23:8] == 16'd0))
    else $error("data beat carries status or wide hash byte");

endmodule

bind song_length_line_parser sllp_checker u_sllp_checker (.*);
